FILE: hdl/chs_pkg.sv
// chs_pkg: shared constants, codes and types of the chained hash set engine.
// Used by every module of the engine but chs_ram; depends on nothing.
`default_nettype none
package chs_pkg;
	localparam int MAX_BUCKETS_DEF  = 256;
	localparam int POOL_ENTRIES_DEF = 768;
	localparam int KEY_BITS_DEF     = 32;
	localparam int RESET_BUCKETS    = 31;
	localparam int CFG_BITS         = 9;
	localparam int HASH_BITS        = 32;
	localparam int COUNT_BITS       = 10;
	localparam int FUNC_BITS        = 2;

	localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 2'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd3;

	// result word status carried from the back part to the result queue
	typedef struct packed {
		logic hit;
		logic full_res;
	} chs_status_t;
endpackage
`default_nettype wire

FILE: hdl/chs_ram.sv
// chs_ram: generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: hdl/chs_front.sv
// chs_front: accepts operation words, reduces the hash to a bucket index and
// queues decoded commands for the back part. Depends on chs_pkg.
`default_nettype none
module chs_front #(
	parameter int KEY_BITS = chs_pkg::KEY_BITS_DEF,
	parameter int IDX_BITS = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [chs_pkg::FUNC_BITS-1:0]  func,
	input  wire logic [KEY_BITS-1:0]            key,
	input  wire logic [chs_pkg::HASH_BITS-1:0]  hash_value,
	input  wire logic [IDX_BITS-1:0]            buckets,
	input  wire logic                           flush,
	output logic                                cmd_valid,
	input  wire logic                           cmd_take,
	output logic [chs_pkg::FUNC_BITS-1:0]       cmd_func,
	output logic [KEY_BITS-1:0]                 cmd_key,
	output logic [IDX_BITS-1:0]                 cmd_head
);
	import chs_pkg::*;

	localparam int RW = HASH_BITS + 1;

	// modulo unit: one restoring step per cycle
	logic                  busy_q;
	logic [5:0]            bit_q;
	logic [RW-1:0]         rem_q;
	logic [HASH_BITS-1:0]  quo_q;
	logic [FUNC_BITS-1:0]  func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [RW-1:0]         shifted;
	logic [RW-1:0]         divisor;

	// two-entry command queue
	logic [1:0]            cnt_q;
	logic                  rd_q;
	logic [FUNC_BITS-1:0]  qf_q [2];
	logic [KEY_BITS-1:0]   qk_q [2];
	logic [IDX_BITS-1:0]   qh_q [2];
	logic                  done;

	assign divisor = RW'(buckets);
	assign shifted = {rem_q[RW-2:0], quo_q[HASH_BITS-1]};
	assign done    = busy_q && (bit_q == 6'd0) && (cnt_q != 2'd2);
	assign full    = busy_q;

	// step the remainder through the hash bits, high bit first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
		end else if (!busy_q && push) begin
			busy_q <= 1'b1;
			bit_q  <= 6'(HASH_BITS);
		end else if (busy_q && bit_q != 6'd0) begin
			bit_q <= bit_q - 6'd1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && push) begin
			rem_q  <= '0;
			quo_q  <= hash_value;
			func_q <= func;
			key_q  <= key;
		end else if (busy_q && bit_q != 6'd0) begin
			quo_q <= {quo_q[HASH_BITS-2:0], 1'b0};
			rem_q <= (shifted >= divisor) ? shifted - divisor : shifted;
		end
	end

	// hold decoded commands until the back part takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
		end else if (flush) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(done) - 2'(cmd_take);
			if (cmd_take) begin
				rd_q <= ~rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			qf_q[rd_q ^ cnt_q[0]] <= func_q;
			qk_q[rd_q ^ cnt_q[0]] <= key_q;
			qh_q[rd_q ^ cnt_q[0]] <= rem_q[IDX_BITS-1:0];
		end
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_func  = qf_q[rd_q];
	assign cmd_key   = qk_q[rd_q];
	assign cmd_head  = qh_q[rd_q];
endmodule
`default_nettype wire

FILE: hdl/chs_back.sv
// chs_back: runs commands against the key and link memories, walks chains,
// sweeps clears and queues result words. Depends on chs_pkg and chs_ram.
`default_nettype none
module chs_back #(
	parameter int KEY_BITS = chs_pkg::KEY_BITS_DEF,
	parameter int POOL_ENTRIES = chs_pkg::POOL_ENTRIES_DEF,
	parameter int IDX_BITS = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [IDX_BITS-1:0]               buckets,
	input  wire logic                              cfg_clear,
	output logic                                   idle,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_take,
	input  wire logic [chs_pkg::FUNC_BITS-1:0]     cmd_func,
	input  wire logic [KEY_BITS-1:0]               cmd_key,
	input  wire logic [IDX_BITS-1:0]               cmd_head,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic                                   hit,
	output logic                                   full_res,
	output logic [chs_pkg::COUNT_BITS-1:0]         element_count
);
	import chs_pkg::*;

	localparam int AW = $clog2(POOL_ENTRIES);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_HEAD  = 4'd1;
	localparam logic [3:0] ST_HCMP  = 4'd2;
	localparam logic [3:0] ST_NRD   = 4'd3;
	localparam logic [3:0] ST_NCMP  = 4'd4;
	localparam logic [3:0] ST_PULL  = 4'd5;
	localparam logic [3:0] ST_PULL2 = 4'd6;
	localparam logic [3:0] ST_UNLK  = 4'd7;
	localparam logic [3:0] ST_INS   = 4'd8;
	localparam logic [3:0] ST_INS2  = 4'd9;
	localparam logic [3:0] ST_INS3  = 4'd10;
	localparam logic [3:0] ST_CLR   = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;
	localparam logic [3:0] ST_WAIT  = 4'd13;

	localparam logic [IDX_BITS-1:0] L_EMPTY = '0;
	localparam logic [IDX_BITS-1:0] L_END   = IDX_BITS'(1);

	logic [3:0]            st_q;
	logic [FUNC_BITS-1:0]  func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [IDX_BITS-1:0]   head_q, prev_q, p_q, hlink_q, nlink_q;
	logic [IDX_BITS-1:0]   free_q, clr_q;
	logic [IDX_BITS:0]     steps_q;
	logic [COUNT_BITS-1:0] count_q;
	chs_status_t           stat_q;
	logic [IDX_BITS-1:0]   pool_end;

	// memory ports
	logic                  k_we, l_we;
	logic [AW-1:0]         k_addr, l_addr;
	logic [KEY_BITS-1:0]   k_wd, k_rd;
	logic [IDX_BITS-1:0]   l_wd, l_rd;

	// result queue, two deep
	logic [1:0]            rc_q;
	logic                  rr_q;
	chs_status_t           rs_q [2];
	logic [COUNT_BITS-1:0] rn_q [2];
	logic                  res_push;

	assign pool_end = IDX_BITS'(buckets * 2'd3);

	function automatic logic lok(input logic [IDX_BITS-1:0] p,
		input logic [IDX_BITS-1:0] b, input logic [IDX_BITS-1:0] e);
		return p != L_END && p >= b && p < e;
	endfunction

	chs_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_ENTRIES)) u_key (
		.clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wd), .rdata(k_rd));
	chs_ram #(.WIDTH(IDX_BITS), .DEPTH(POOL_ENTRIES)) u_link (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));

	assign cmd_take = (st_q == ST_IDLE) && cmd_valid && !cfg_clear;
	assign res_push = (st_q == ST_DONE) && (rc_q != 2'd2);
	assign idle     = (st_q == ST_IDLE) && !cmd_valid;

	// drive memory ports from the state
	always_comb begin
		k_we = 1'b0; l_we = 1'b0;
		k_addr = AW'(head_q); l_addr = AW'(head_q);
		k_wd = key_q; l_wd = L_EMPTY;
		unique case (st_q)
			ST_IDLE: begin
				k_addr = AW'(cmd_head); l_addr = AW'(cmd_head);
			end
			ST_HCMP: begin
				if (l_rd != L_EMPTY && k_rd == key_q && func_q == FUNC_REMOVE) begin
					if (lok(l_rd, buckets, pool_end)) begin
						// read the follower of the head
						k_addr = AW'(l_rd); l_addr = AW'(l_rd);
					end else begin
						// lone head: mark the bucket empty
						l_we = 1'b1; l_wd = L_EMPTY;
					end
				end else if (l_rd == L_EMPTY && func_q == FUNC_INSERT) begin
					k_we = 1'b1; l_we = 1'b1; l_wd = L_END;
				end else begin
					k_addr = AW'(l_rd); l_addr = AW'(l_rd);
				end
			end
			ST_NRD: begin
				k_addr = AW'(p_q); l_addr = AW'(p_q);
			end
			ST_PULL: begin
				k_we = 1'b1; k_wd = k_rd; l_we = 1'b1; l_wd = l_rd;
			end
			ST_PULL2: begin
				l_addr = AW'(p_q); l_we = 1'b1; l_wd = free_q;
			end
			ST_UNLK: begin
				l_addr = AW'(prev_q); l_we = 1'b1; l_wd = nlink_q;
			end
			ST_INS: begin
				l_addr = AW'(free_q);
			end
			ST_INS2: begin
				k_addr = AW'(p_q); k_we = 1'b1;
				l_addr = AW'(p_q); l_we = 1'b1; l_wd = hlink_q;
			end
			ST_INS3: begin
				l_we = 1'b1; l_wd = p_q;
			end
			ST_CLR: begin
				l_addr = AW'(clr_q); l_we = 1'b1;
				if (clr_q < buckets) l_wd = L_EMPTY;
				else if (clr_q + 1'b1 == pool_end) l_wd = L_END;
				else l_wd = clr_q + 1'b1;
			end
			default: ;
		endcase
	end

	// sequence one command at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			clr_q   <= '0;
			free_q  <= IDX_BITS'(RESET_BUCKETS);
			count_q <= '0;
			stat_q  <= '0;
			func_q  <= FUNC_INSERT;
		end else if (cfg_clear) begin
			st_q    <= ST_CLR;
			clr_q   <= '0;
			free_q  <= buckets;
			count_q <= '0;
			func_q  <= FUNC_INSERT;
		end else begin
			unique case (st_q)
				ST_IDLE: if (cmd_valid) begin
					func_q <= cmd_func; key_q <= cmd_key; head_q <= cmd_head;
					stat_q <= '0;
					if (cmd_func == FUNC_CLEAR) begin
						st_q <= ST_CLR; clr_q <= '0; free_q <= buckets; count_q <= '0;
					end else begin
						st_q <= ST_HEAD;
					end
				end
				ST_HEAD: st_q <= ST_HCMP;
				ST_HCMP: begin
					hlink_q <= l_rd;
					if (l_rd == L_EMPTY) begin
						if (func_q == FUNC_INSERT) count_q <= count_q + 1'b1;
						st_q <= ST_DONE;
					end else if (k_rd == key_q) begin
						stat_q.hit <= 1'b1;
						if (func_q == FUNC_REMOVE) begin
							count_q <= count_q - 1'b1;
							p_q <= l_rd;
							st_q <= lok(l_rd, buckets, pool_end) ? ST_PULL : ST_DONE;
						end else begin
							st_q <= ST_DONE;
						end
					end else begin
						prev_q <= head_q; p_q <= l_rd; steps_q <= '0;
						st_q <= lok(l_rd, buckets, pool_end) ? ST_NCMP : ST_INS;
					end
				end
				ST_NRD: st_q <= ST_NCMP;
				ST_NCMP: begin
					nlink_q <= l_rd;
					if (k_rd == key_q) begin
						stat_q.hit <= 1'b1;
						if (func_q == FUNC_REMOVE) begin
							count_q <= count_q - 1'b1;
							st_q <= ST_UNLK;
						end else begin
							st_q <= ST_DONE;
						end
					end else if (lok(l_rd, buckets, pool_end) &&
						steps_q + 1'b1 < (IDX_BITS+1)'(POOL_ENTRIES)) begin
						prev_q <= p_q; p_q <= l_rd; steps_q <= steps_q + 1'b1;
						st_q <= ST_NRD;
					end else begin
						st_q <= ST_INS;
					end
				end
				ST_PULL: st_q <= ST_PULL2;
				ST_PULL2: begin
					free_q <= p_q; st_q <= ST_DONE;
				end
				ST_UNLK: st_q <= ST_PULL2;
				ST_INS: begin
					if (func_q != FUNC_INSERT) begin
						st_q <= ST_DONE;
					end else if (!lok(free_q, buckets, pool_end)) begin
						stat_q.full_res <= 1'b1; st_q <= ST_DONE;
					end else begin
						p_q <= free_q; st_q <= ST_INS2;
					end
				end
				ST_INS2: begin
					free_q <= l_rd; st_q <= ST_INS3;
				end
				ST_INS3: begin
					count_q <= count_q + 1'b1; st_q <= ST_DONE;
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q + 1'b1 == pool_end) begin
						st_q <= (func_q == FUNC_CLEAR) ? ST_DONE : ST_WAIT;
						func_q <= FUNC_INSERT;
						free_q <= buckets;
					end
				end
				ST_DONE: if (rc_q != 2'd2) st_q <= ST_IDLE;
				ST_WAIT: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// queue result words toward the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			rr_q <= 1'b0;
		end else begin
			rc_q <= rc_q + 2'(res_push) - 2'(pop && !empty);
			if (pop && !empty) rr_q <= ~rr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rs_q[rr_q ^ rc_q[0]] <= stat_q;
			rn_q[rr_q ^ rc_q[0]] <= count_q;
		end
	end

	assign empty         = (rc_q == 2'd0);
	assign hit           = rs_q[rr_q].hit;
	assign full_res      = rs_q[rr_q].full_res;
	assign element_count = rn_q[rr_q];
endmodule
`default_nettype wire

FILE: hdl/chained_hash_set_engine_top.sv
// Chained hash set engine: a hash set of keys held in a pool of entries
// (bucket heads plus chained spares on a free list). Accepts one operation
// (insert, remove, lookup, clear) at a time and returns one result word per
// operation. After an operation is accepted, full stays high while the front
// part forms the bucket index one hash bit per cycle and until that index is
// queued for the back part, so the front takes no new operation before then.
// The back part overlaps with it and works through a single-port key memory
// and link memory. Clear and a bucket_count write sweep the link memory over
// all 3*bucket_count pool entries; after reset that sweep runs before the
// first operation is carried out. cfg_ready is high only while the engine
// holds no operation.
// Depends on chs_pkg, chs_front, chs_back, chs_ram.
`default_nettype none
module chained_hash_set_engine_top #(
	parameter int MAX_BUCKETS  = chs_pkg::MAX_BUCKETS_DEF,
	parameter int POOL_ENTRIES = chs_pkg::POOL_ENTRIES_DEF,
	parameter int KEY_BITS     = chs_pkg::KEY_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [chs_pkg::FUNC_BITS-1:0]  func,
	input  wire logic [KEY_BITS-1:0]            key,
	input  wire logic [chs_pkg::HASH_BITS-1:0]  hash_value,
	output logic                                empty,
	input  wire logic                           pop,
	output logic                                hit,
	output logic                                full_res,
	output logic [chs_pkg::COUNT_BITS-1:0]      element_count,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [chs_pkg::CFG_BITS-1:0]   cfg_data
);
	import chs_pkg::*;

	localparam int LIM = (MAX_BUCKETS < POOL_ENTRIES/3) ? MAX_BUCKETS : POOL_ENTRIES/3;
	localparam int IDX_BITS = $clog2(POOL_ENTRIES) + 1;

	logic [IDX_BITS-1:0] buckets_q, clamped, buckets_sel;
	logic                cfg_clear, back_idle;
	logic                cmd_valid, cmd_take;
	logic [FUNC_BITS-1:0] cmd_func;
	logic [KEY_BITS-1:0] cmd_key;
	logic [IDX_BITS-1:0] cmd_head;

	// clamp written bucket count into range
	always_comb begin
		if (32'(cfg_data) > 32'(LIM)) clamped = IDX_BITS'(LIM);
		else if (cfg_data < CFG_BITS'(2)) clamped = IDX_BITS'(2);
		else clamped = IDX_BITS'(cfg_data);
	end

	assign cfg_ready = back_idle && !full;
	assign cfg_clear = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buckets_q <= IDX_BITS'((RESET_BUCKETS > LIM) ? LIM : RESET_BUCKETS);
		end else if (cfg_clear) begin
			buckets_q <= clamped;
		end
	end

	// new size applies during the clear it starts
	assign buckets_sel = cfg_clear ? clamped : buckets_q;

	chs_front #(.KEY_BITS(KEY_BITS), .IDX_BITS(IDX_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.key(key), .hash_value(hash_value), .buckets(buckets_q),
		.flush(1'b0), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd_func(cmd_func), .cmd_key(cmd_key), .cmd_head(cmd_head));

	chs_back #(.KEY_BITS(KEY_BITS), .POOL_ENTRIES(POOL_ENTRIES),
		.IDX_BITS(IDX_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .buckets(buckets_sel), .cfg_clear(cfg_clear),
		.idle(back_idle), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd_func(cmd_func), .cmd_key(cmd_key), .cmd_head(cmd_head),
		.empty(empty), .pop(pop), .hit(hit), .full_res(full_res),
		.element_count(element_count));
endmodule
`default_nettype wire

FILE: hdl/chs_checker.sv
// chs_checker: port-level assertions for the chained hash set engine top.
// Uses no package; bound to chained_hash_set_engine_top.
`default_nettype none
module chs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       push,
	input wire logic       full,
	input wire logic       pop,
	input wire logic       empty,
	input wire logic       hit,
	input wire logic       full_res,
	input wire logic [9:0] element_count
);
	// a full result never reports a hit
	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(hit && full_res)) else $error("full with hit");
	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(element_count)))
		else $error("result dropped");
	// count stays within the pool
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> element_count <= 10'd768) else $error("count range");
	// an accepted word blocks the input while it is decoded
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full) else $error("input not held off");
endmodule

bind chained_hash_set_engine_top chs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pop(pop),
	.empty(empty), .hit(hit), .full_res(full_res),
	.element_count(element_count));
`default_nettype wire

FILE: tb/sv/chs_result_checker.sv
// chs_result_checker: predicts the chained hash set engine's result words and
// compares them with what the engine returns. Depends on chs_pkg.
`default_nettype none
module chs_result_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic                          full,
	input  wire logic [chs_pkg::FUNC_BITS-1:0] func,
	input  wire logic [31:0]                   key,
	input  wire logic [31:0]                   hash_value,
	input  wire logic                          empty,
	input  wire logic                          pop,
	input  wire logic                          hit,
	input  wire logic                          full_res,
	input  wire logic [9:0]                    element_count,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [8:0]                    cfg_data,
	output int                                 fail_count,
	output int                                 pending
);
	import chs_pkg::*;

	localparam int POOL = POOL_ENTRIES_DEF;
	localparam logic [9:0] LINK_EMPTY = 10'd0;
	localparam logic [9:0] LINK_END   = 10'd1;

	typedef struct packed {
		logic       hit;
		logic       full_res;
		logic [9:0] count;
	} set_answer_t;

	logic [31:0] keys [POOL];
	logic [9:0]  links [POOL];
	logic [9:0]  free_top;
	logic [9:0]  live_keys;
	logic [9:0]  buckets;
	set_answer_t answers [$];

	function automatic logic [9:0] clamp_size(logic [8:0] v);
		int lim;
		lim = MAX_BUCKETS_DEF;
		if (lim > POOL / 3) lim = POOL / 3;
		if (v > lim) return 10'(lim);
		if (v < 2) return 10'd2;
		return 10'(v);
	endfunction

	function automatic bit walkable(logic [9:0] p);
		return p != LINK_END && p >= buckets && int'(p) < 3 * int'(buckets);
	endfunction

	task automatic empty_set();
		int pool_end;
		pool_end = 3 * int'(buckets);
		for (int i = 0; i < int'(buckets); i++) links[i] = LINK_EMPTY;
		for (int i = int'(buckets); i + 1 < pool_end; i++) links[i] = 10'(i + 1);
		links[pool_end - 1] = LINK_END;
		free_top = buckets;
		live_keys = '0;
	endtask

	// Apply one operation to the shadow set and queue the expected word.
	task automatic apply_op(logic [1:0] op, logic [31:0] k, logic [31:0] h);
		logic [9:0] head, p, prev;
		logic found, no_room;
		set_answer_t a;
		head = 10'(h % buckets);
		found = 0;
		no_room = 0;
		if (op == FUNC_CLEAR) begin
			empty_set();
		end else if (links[head] != LINK_EMPTY) begin
			if (keys[head] == k) begin
				found = 1;
				if (op == FUNC_REMOVE) begin
					p = links[head];
					if (walkable(p)) begin
						keys[head] = keys[p];
						links[head] = links[p];
						links[p] = free_top;
						free_top = p;
					end else begin
						links[head] = LINK_EMPTY;
					end
					live_keys--;
				end
			end else begin
				prev = head;
				p = links[head];
				for (int s = 0; walkable(p) && s < POOL; s++) begin
					if (keys[p] == k) begin
						found = 1;
						break;
					end
					prev = p;
					p = links[p];
				end
				if (found && op == FUNC_REMOVE) begin
					links[prev] = links[p];
					links[p] = free_top;
					free_top = p;
					live_keys--;
				end else if (!found && op == FUNC_INSERT) begin
					if (walkable(free_top)) begin
						p = free_top;
						free_top = links[p];
						keys[p] = k;
						links[p] = links[head];
						links[head] = p;
						live_keys++;
					end else begin
						no_room = 1;
					end
				end
			end
		end else if (op == FUNC_INSERT) begin
			keys[head] = k;
			links[head] = LINK_END;
			live_keys++;
		end
		a.hit = found;
		a.full_res = no_room;
		a.count = live_keys;
		answers.push_back(a);
	endtask

	// Track the set and compare each popped word with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		set_answer_t want;
		if (!arst_n) begin
			fail_count <= 0;
			answers.delete();
			for (int i = 0; i < POOL; i++) keys[i] = '0;
			buckets = clamp_size(9'(RESET_BUCKETS));
			empty_set();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (answers.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected word: hit=%0b full_res=%0b count=%0d",
							hit, full_res, element_count);
				end else begin
					want = answers.pop_front();
					if (want.hit !== hit || want.full_res !== full_res ||
						want.count !== element_count) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected hit=%0b full_res=%0b count=%0d, got hit=%0b full_res=%0b count=%0d",
								want.hit, want.full_res, want.count,
								hit, full_res, element_count);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				buckets = clamp_size(cfg_data);
				empty_set();
			end
			if (push && !full) apply_op(func, key, hash_value);
			pending <= answers.size();
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/tb_chained_hash_set_engine_top.sv
// tb_chained_hash_set_engine_top: drives random and directed set operations and
// bucket_count writes into the engine. Depends on chs_pkg, the engine, chs_result_checker.
`default_nettype none
module tb_chained_hash_set_engine_top;
	import chs_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic [1:0] func = FUNC_LOOKUP;
	logic [31:0] key = '0;
	logic [31:0] hash_value = '0;
	logic pop = 0;
	logic cfg_valid = 0;
	logic [8:0] cfg_data = '0;
	logic full, empty, hit, full_res, cfg_ready;
	logic [9:0] element_count;
	int fail_count, pending;
	int pop_idle = 0;
	bit calm = 0;
	logic [31:0] key_pool [16];

	chained_hash_set_engine_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.key(key), .hash_value(hash_value), .empty(empty), .pop(pop), .hit(hit),
		.full_res(full_res), .element_count(element_count), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	chs_result_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.key(key), .hash_value(hash_value), .empty(empty), .pop(pop), .hit(hit),
		.full_res(full_res), .element_count(element_count), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Send one word, with a random gap before it while idling is on.
	task automatic send_op(logic [1:0] op, logic [31:0] k, logic [31:0] h);
		int gap;
		gap = 1;
		if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
		repeat (gap) @(posedge clk);
		push <= 1;
		func <= op;
		key <= k;
		hash_value <= h;
		do @(posedge clk); while (full);
		push <= 0;
	endtask

	// Wait for every result, then let the engine settle.
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_buckets(logic [8:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		repeat (3 * 256 + 40) @(posedge clk);
	endtask

	// Mostly keys from a small pool so that duplicates, removes and hits occur.
	task automatic random_ops(int n, int fill_bias);
		logic [31:0] k, h;
		logic [1:0] op;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < fill_bias) op = FUNC_INSERT;
			else if (r < fill_bias + 25) op = FUNC_REMOVE;
			else if (r < 99) op = FUNC_LOOKUP;
			else op = FUNC_CLEAR;
			if ($urandom_range(0, 9) < 7) begin
				r = $urandom_range(0, 15);
				k = key_pool[r];
				h = (r % 3 == 0) ? 32'(r) : ~32'(r * 7);
			end else begin
				k = $urandom;
				h = $urandom;
			end
			send_op(op, k, h);
		end
	endtask

	// Pop with random stall bursts while idling is on.
	always @(posedge clk) begin
		if (pop_idle > 0) begin
			pop_idle <= pop_idle - 1;
			pop <= 0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			pop_idle <= $urandom_range(0, 18);
			pop <= 0;
		end else begin
			pop <= 1;
		end
	end

	initial begin
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		drain();
		// Directed: extremes, every operation, duplicates, head removal, misses.
		send_op(FUNC_LOOKUP, 32'h0, 32'h0);
		send_op(FUNC_REMOVE, 32'h0, 32'h0);
		send_op(FUNC_INSERT, 32'h0, 32'h0);
		send_op(FUNC_INSERT, 32'h0, 32'h0);
		send_op(FUNC_INSERT, 32'hFFFF_FFFF, 32'd31);
		send_op(FUNC_INSERT, 32'h1234_5678, 32'hFFFF_FFFF);
		send_op(FUNC_INSERT, 32'hA5A5_5A5A, 32'd62);
		send_op(FUNC_LOOKUP, 32'hA5A5_5A5A, 32'd0);
		send_op(FUNC_LOOKUP, 32'h5555_AAAA, 32'd0);
		send_op(FUNC_REMOVE, 32'h0, 32'd93);
		send_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send_op(FUNC_REMOVE, 32'hA5A5_5A5A, 32'd0);
		send_op(FUNC_REMOVE, 32'h7777_7777, 32'd0);
		send_op(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		// Hold off until every result is back.
		drain();
		// Small table filled past its pool: full results.
		write_buckets(9'd0);
		for (int i = 0; i < 9; i++) send_op(FUNC_INSERT, 32'(i * 3 + 1), 32'(i));
		send_op(FUNC_REMOVE, 32'd1, 32'd0);
		send_op(FUNC_INSERT, 32'd500, 32'd1);
		random_ops(120, 45);
		write_buckets(9'd1);
		random_ops(120, 40);
		write_buckets(9'h1FF);
		random_ops(250, 45);
		write_buckets(9'd3);
		random_ops(250, 55);
		write_buckets(9'd256);
		random_ops(150, 40);
		write_buckets(9'd255);
		random_ops(150, 40);
		write_buckets(9'd31);
		random_ops(250, 45);
		calm = 1;
		random_ops(220, 45);
		drain();
		if (fail_count == 0)
			$display("tb_chained_hash_set_engine_top: PASS");
		else
			$display("tb_chained_hash_set_engine_top: FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("tb_chained_hash_set_engine_top: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
